// ===== rtl/sccb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB master package
// Types, codes and reset values shared by the SCCB register access master.
// ----------------------------------------------------------------------------
package sccb_pkg;

  localparam int unsigned DevAddrW  = 7;
  localparam int unsigned PhaseW    = 8;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [DevAddrW-1:0] DevAddrRst = 7'd33;
  localparam logic [PhaseW-1:0]   PhaseRst   = 8'd2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEV_ADDR    = 1'b0,
    CFG_PHASE_TICKS = 1'b1
  } cfg_idx_e;

  // Bus sequencer stages
  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_START_A  = 4'd1,
    ST_DEV_W    = 4'd2,
    ST_REG      = 4'd3,
    ST_DATA     = 4'd4,
    ST_STOP_END = 4'd5,
    ST_STOP_MID = 4'd6,
    ST_START_B  = 4'd7,
    ST_DEV_R    = 4'd8,
    ST_READ     = 4'd9,
    ST_NOACK    = 4'd10
  } step_e;

  typedef struct packed {
    logic             req_valid;
    logic             req_type;
    logic [ByteW-1:0] reg_addr;
    logic [ByteW-1:0] write_data;
    logic             sda_in;
  } sccb_req_t;

  typedef struct packed {
    logic             scl;
    logic             sda_out;
    logic             sda_drive;
    logic             busy_res;
    logic             done_res;
    logic             success;
    logic [ByteW-1:0] read_data;
  } sccb_res_t;

  typedef struct packed {
    logic [DevAddrW-1:0] dev_addr;
    logic [PhaseW-1:0]   phase_ticks;
  } sccb_cfg_t;

endpackage

// ===== rtl/sccb_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB tick channel
// Valid/ready channel that carries one input tick item.
// ----------------------------------------------------------------------------
interface sccb_req_if;
  logic               valid;
  logic               ready;
  sccb_pkg::sccb_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sccb_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB result channel
// Valid/ready channel that carries one result item per tick.
// ----------------------------------------------------------------------------
interface sccb_res_if;
  logic               valid;
  logic               ready;
  sccb_pkg::sccb_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sccb_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB configuration registers
// Holds the device address and the phase hold length.
// ----------------------------------------------------------------------------
module sccb_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sccb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sccb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output sccb_pkg::sccb_cfg_t            cfg_o
);

  sccb_pkg::sccb_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sccb_pkg::cfg_idx_e'(cfg_idx_i))
        sccb_pkg::CFG_DEV_ADDR:    cfg_d.dev_addr    = cfg_wdata_i[sccb_pkg::DevAddrW-1:0];
        sccb_pkg::CFG_PHASE_TICKS: cfg_d.phase_ticks = cfg_wdata_i[sccb_pkg::PhaseW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= sccb_pkg::DevAddrRst;
      cfg_q.phase_ticks <= sccb_pkg::PhaseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/sccb_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB bus sequencer
// Advances the pin-level start/byte/ack/read/stop sequence by one tick.
// ----------------------------------------------------------------------------
module sccb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  sccb_pkg::sccb_req_t tick_i,
  input  sccb_pkg::sccb_cfg_t cfg_i,
  output sccb_pkg::sccb_res_t res_o
);

  sccb_pkg::step_e st_d, st_q;
  logic [1:0]                  sub_d, sub_q;
  logic [3:0]                  bit_d, bit_q;
  logic [sccb_pkg::PhaseW-1:0] pc_d, pc_q;
  logic [sccb_pkg::ByteW-1:0]  shift_d, shift_q;
  logic [sccb_pkg::ByteW-1:0]  rx_d, rx_q;
  logic [sccb_pkg::ByteW-1:0]  lreg_d, lreg_q;
  logic [sccb_pkg::ByteW-1:0]  ldat_d, ldat_q;
  logic                        rd_d, rd_q;
  logic                        nack_d, nack_q;
  logic                        scl_d, scl_q;
  logic                        sda_d, sda_q;
  logic                        drv_d, drv_q;

  logic enter, go_idle, dec, new_req, done;
  logic [sccb_pkg::ByteW-1:0] addr_w;

  assign addr_w = {cfg_i.dev_addr, 1'b0};

  // Next stage, sub-phase and bit
  always_comb begin
    st_d    = st_q;
    sub_d   = sub_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    rd_d    = rd_q;
    lreg_d  = lreg_q;
    ldat_d  = ldat_q;
    enter   = 1'b0;
    go_idle = 1'b0;
    dec     = 1'b0;
    new_req = 1'b0;
    done    = 1'b0;
    if (step_i) begin
      if (st_q == sccb_pkg::ST_IDLE) begin
        sub_d = 2'd0;
        if (tick_i.req_valid) begin
          new_req = 1'b1;
          rd_d    = tick_i.req_type;
          lreg_d  = tick_i.reg_addr;
          ldat_d  = tick_i.write_data;
          enter   = 1'b1;
          st_d    = sccb_pkg::ST_START_A;
          bit_d   = 4'd0;
        end
      end else if (pc_q != '0) begin
        dec = 1'b1;
      end else begin
        enter = 1'b1;
        unique case (st_q)
          sccb_pkg::ST_START_A, sccb_pkg::ST_START_B: begin
            bit_d = 4'd0;
            if (sub_q != 2'd3) begin
              sub_d = sub_q + 2'd1;
            end else begin
              sub_d   = 2'd0;
              st_d    = (st_q == sccb_pkg::ST_START_A) ? sccb_pkg::ST_DEV_W : sccb_pkg::ST_DEV_R;
              shift_d = (st_q == sccb_pkg::ST_START_A) ? addr_w : (addr_w | 8'h01);
            end
          end
          sccb_pkg::ST_DEV_W, sccb_pkg::ST_REG, sccb_pkg::ST_DATA, sccb_pkg::ST_DEV_R: begin
            if (!bit_q[3]) begin
              if (sub_q != 2'd2) begin
                sub_d = sub_q + 2'd1;
              end else begin
                sub_d = 2'd0;
                bit_d = bit_q + 4'd1;
              end
            end else if (sub_q != 2'd3) begin
              sub_d = sub_q + 2'd1;
            end else begin
              sub_d = 2'd0;
              bit_d = 4'd0;
              if (nack_q) begin
                st_d = sccb_pkg::ST_STOP_END;
              end else if (st_q == sccb_pkg::ST_DEV_W) begin
                st_d    = sccb_pkg::ST_REG;
                shift_d = lreg_q;
              end else if (st_q == sccb_pkg::ST_REG) begin
                if (rd_q) begin
                  st_d = sccb_pkg::ST_STOP_MID;
                end else begin
                  st_d    = sccb_pkg::ST_DATA;
                  shift_d = ldat_q;
                end
              end else if (st_q == sccb_pkg::ST_DATA) begin
                st_d = sccb_pkg::ST_STOP_END;
              end else begin
                st_d = sccb_pkg::ST_READ;
              end
            end
          end
          sccb_pkg::ST_READ: begin
            if (sub_q != 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else if (bit_q < 4'd7) begin
              sub_d = 2'd0;
              bit_d = bit_q + 4'd1;
            end else begin
              st_d  = sccb_pkg::ST_NOACK;
              sub_d = 2'd0;
              bit_d = 4'd0;
            end
          end
          sccb_pkg::ST_NOACK: begin
            bit_d = 4'd0;
            if (sub_q != 2'd3) begin
              sub_d = sub_q + 2'd1;
            end else begin
              st_d  = sccb_pkg::ST_STOP_END;
              sub_d = 2'd0;
            end
          end
          sccb_pkg::ST_STOP_MID: begin
            bit_d = 4'd0;
            if (sub_q != 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else begin
              st_d  = sccb_pkg::ST_START_B;
              sub_d = 2'd0;
            end
          end
          sccb_pkg::ST_STOP_END: begin
            bit_d = 4'd0;
            if (sub_q != 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else begin
              enter   = 1'b0;
              go_idle = 1'b1;
              done    = 1'b1;
              st_d    = sccb_pkg::ST_IDLE;
              sub_d   = 2'd0;
            end
          end
          default: begin
            enter   = 1'b0;
            go_idle = 1'b1;
            st_d    = sccb_pkg::ST_IDLE;
            sub_d   = 2'd0;
            bit_d   = 4'd0;
          end
        endcase
      end
    end
  end

  // Line levels, sampling and hold counter of the phase being entered
  always_comb begin
    pc_d   = pc_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    drv_d  = drv_q;
    nack_d = new_req ? 1'b0 : nack_q;
    rx_d   = new_req ? '0 : rx_q;
    if (dec) begin
      pc_d = pc_q - 8'd1;
    end
    if (go_idle) begin
      pc_d = '0;
    end
    if (enter) begin
      pc_d = (cfg_i.phase_ticks == '0) ? '0 : cfg_i.phase_ticks - 8'd1;
      unique case (st_d)
        sccb_pkg::ST_START_A, sccb_pkg::ST_START_B: begin
          case (sub_d)
            2'd0:    begin sda_d = 1'b1; drv_d = 1'b1; end
            2'd1:    scl_d = 1'b1;
            2'd2:    begin sda_d = 1'b0; drv_d = 1'b1; end
            default: scl_d = 1'b0;
          endcase
        end
        sccb_pkg::ST_DEV_W, sccb_pkg::ST_REG, sccb_pkg::ST_DATA, sccb_pkg::ST_DEV_R: begin
          if (!bit_d[3]) begin
            case (sub_d)
              2'd0:    begin sda_d = shift_d[~bit_d[2:0]]; drv_d = 1'b1; end
              2'd1:    scl_d = 1'b1;
              default: scl_d = 1'b0;
            endcase
          end else begin
            // acknowledge slot: release data, sample on the third phase
            case (sub_d)
              2'd0:    begin sda_d = 1'b1; drv_d = 1'b0; end
              2'd1:    scl_d = 1'b1;
              2'd2:    nack_d = tick_i.sda_in;
              default: scl_d = 1'b0;
            endcase
          end
        end
        sccb_pkg::ST_READ: begin
          case (sub_d)
            2'd0: begin sda_d = 1'b0; drv_d = 1'b0; scl_d = 1'b1; end
            2'd1: begin
              if (tick_i.sda_in && !bit_d[3]) begin
                rx_d[~bit_d[2:0]] = 1'b1;
              end
            end
            default: scl_d = 1'b0;
          endcase
        end
        sccb_pkg::ST_NOACK: begin
          case (sub_d)
            2'd0:    begin sda_d = 1'b1; drv_d = 1'b1; end
            2'd1:    scl_d = 1'b1;
            2'd2:    scl_d = 1'b0;
            default: begin sda_d = 1'b0; drv_d = 1'b1; end
          endcase
        end
        sccb_pkg::ST_STOP_END, sccb_pkg::ST_STOP_MID: begin
          case (sub_d)
            2'd0:    begin sda_d = 1'b0; drv_d = 1'b1; end
            2'd1:    scl_d = 1'b1;
            default: begin sda_d = 1'b1; drv_d = 1'b1; end
          endcase
        end
        default: pc_d = pc_d;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= sccb_pkg::ST_IDLE;
      sub_q   <= '0;
      bit_q   <= '0;
      pc_q    <= '0;
      shift_q <= '0;
      rx_q    <= '0;
      lreg_q  <= '0;
      ldat_q  <= '0;
      rd_q    <= 1'b0;
      nack_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      drv_q   <= 1'b1;
    end else begin
      st_q    <= st_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      pc_q    <= pc_d;
      shift_q <= shift_d;
      rx_q    <= rx_d;
      lreg_q  <= lreg_d;
      ldat_q  <= ldat_d;
      rd_q    <= rd_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      drv_q   <= drv_d;
    end
  end

  always_comb begin
    res_o.scl       = scl_d;
    res_o.sda_out   = sda_d;
    res_o.sda_drive = drv_d;
    res_o.busy_res  = (st_d != sccb_pkg::ST_IDLE);
    res_o.done_res  = done;
    res_o.success   = done && !nack_d;
    res_o.read_data = (done && !nack_d && rd_d) ? rx_d : '0;
  end

endmodule

// ===== rtl/sccb_register_access_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCCB register access master
// Pin-level SCCB master for one camera register write or read per request.
// ----------------------------------------------------------------------------
// Path: a tick item is taken into the input register, then the sequencer step
//   writes its result into the result register that drives the result channel.
// Throughput: one tick item per cycle; while a result waits the input
//   register takes one more item, then the input side stalls.
// Reset: asynchronous, active low; sequencer idle, clock and data high and
//   driven, configuration back to address 33 and two ticks per phase.
module sccb_register_access_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sccb_req_if.sink                      req_i,
  sccb_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [sccb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sccb_pkg::CfgDataW-1:0] cfg_wdata_i
);

  sccb_pkg::sccb_cfg_t cfg;
  sccb_pkg::sccb_req_t in_data_q;
  sccb_pkg::sccb_res_t out_data_q, seq_res;
  logic                in_vld_q, out_vld_q;
  logic                adv, step;

  assign adv         = !out_vld_q || res_o.ready;
  assign step        = in_vld_q && adv;
  assign req_i.ready = !in_vld_q || adv;

  sccb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sccb_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .tick_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (seq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_data_q <= req_i.data;
    end
    if (step) begin
      out_data_q <= seq_res;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_data_q;

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("stepped item did not reach the result register");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q.done_res |-> !out_data_q.busy_res)
    else $error("done reported while still busy");

  a_success_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q.success |-> out_data_q.done_res)
    else $error("success without done");

  a_rdata_with_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_data_q.read_data != '0) |-> out_data_q.success)
    else $error("read data shown without a successful end");

  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_data_q.busy_res |->
      out_data_q.scl && out_data_q.sda_out && out_data_q.sda_drive)
    else $error("bus lines not released high while idle");

endmodule
